>>> hw/rtl/cblm_pkg.sv
package cblm_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int ADDR_W = 32;
    localparam int PFX_W = 6;
    localparam int ENTRY_W = ADDR_W + PFX_W;
    localparam logic [PFX_W-1:0] MAX_PREFIX = PFX_W'(32);
    localparam logic [ADDR_W-1:0] FULL_MASK = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STS_ADDED = 2'd0,
        STS_DUP   = 2'd1,
        STS_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    function automatic logic [PFX_W-1:0] clamp_prefix(input logic [PFX_W-1:0] p);
        return (p > MAX_PREFIX) ? MAX_PREFIX : p;
    endfunction

    function automatic logic [ADDR_W-1:0] mask_of(input logic [PFX_W-1:0] p);
        logic [PFX_W-1:0] sh;
        sh = MAX_PREFIX - p;
        if (p == '0)
        begin
            return '0;
        end
        return FULL_MASK << sh;
    endfunction

endpackage

>>> hw/rtl/cidr_ban_list_matcher.sv
// CIDR ban list matcher: a table of TABLE_ENTRIES IPv4 address/prefix filters.
// Command channel: a beat (action, address, prefix_len) is taken on a rising
// edge with start high and busy low. busy stays high until the result is out.
// Result channel: done pulses for one cycle with hit, status, removed_count
// valid in that cycle only; the receiver must take it then and cannot stall.
// Every command walks all entries through the one masked compare unit, one
// entry per cycle, reading the entry RAM through a registered read.
// The walk runs in state SCAN, then done is raised in state FINISH; a new
// command is taken only once busy is low again. An insert writes its free
// slot in the done cycle; a remove clears valid bits during the walk.
// Reset clears the FSM and all valid bits at once, so the table is empty with
// no clearing pass; entry RAM contents are only read behind a valid bit.
module cidr_ban_list_matcher
    import cblm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          action,
    input  logic [ADDR_W-1:0]   address,
    input  logic [PFX_W-1:0]    prefix_len,
    output logic                done,
    output logic                hit,
    output logic [1:0]          status,
    output logic [6:0]          removed_count
);

    state_t state_reg, state_next;

    action_t            act_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [PFX_W-1:0]   pfx_reg;
    logic [ADDR_W-1:0]  key_mask_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   pipe_idx_reg;
    logic               pipe_vld_reg;
    logic               hit_reg;
    logic               dup_reg;
    logic               free_found_reg;
    logic [IDX_W-1:0]   free_idx_reg;
    logic [6:0]         count_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;

    logic               accept;
    logic               scan_end;
    logic               ram_we;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [ADDR_W-1:0]  ent_addr;
    logic [PFX_W-1:0]   ent_pfx;
    logic [ADDR_W-1:0]  ent_mask;
    logic [ADDR_W-1:0]  cmp_lhs;
    logic [ADDR_W-1:0]  cmp_rhs;
    logic               ent_valid;
    logic               match;
    logic               do_write;

    assign accept   = start && !busy;
    assign scan_end = (idx_reg == CNT_W'(TABLE_ENTRIES));

    cblm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (free_idx_reg),
        .wdata (ram_wdata),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign ram_wdata = {pfx_reg, addr_reg};
    assign ent_addr  = ram_rdata[ADDR_W-1:0];
    assign ent_pfx   = ram_rdata[ENTRY_W-1:ADDR_W];
    assign ent_mask  = mask_of(ent_pfx);

    // shared compare: entry masked by its own mask vs. address masked by
    // the entry mask (lookup/remove) or by the new filter mask (insert)
    assign cmp_lhs   = ent_addr & ent_mask;
    assign cmp_rhs   = addr_reg & ((act_reg == ACT_INSERT) ? key_mask_reg : ent_mask);
    assign ent_valid = valid_reg[pipe_idx_reg];
    assign match     = pipe_vld_reg && ent_valid && (cmp_lhs == cmp_rhs);
    assign do_write  = (act_reg == ACT_INSERT) && !dup_reg && free_found_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy   = 1'b1;
        done   = 1'b0;
        ram_we = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_SCAN:
            begin
                busy = 1'b1;
            end
            ST_FINISH:
            begin
                done   = 1'b1;
                ram_we = do_write;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            idx_reg        <= '0;
            pipe_vld_reg   <= 1'b0;
            hit_reg        <= 1'b0;
            dup_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            count_reg      <= '0;
        end
        else
        begin
            if (accept)
            begin
                idx_reg        <= '0;
                pipe_vld_reg   <= 1'b0;
                hit_reg        <= 1'b0;
                dup_reg        <= 1'b0;
                free_found_reg <= 1'b0;
                count_reg      <= '0;
            end
            else if (state_reg == ST_SCAN)
            begin
                pipe_vld_reg <= !scan_end;
                if (!scan_end)
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
                if (match)
                begin
                    case (act_reg)
                        ACT_LOOKUP:
                        begin
                            hit_reg <= 1'b1;
                        end
                        ACT_INSERT:
                        begin
                            dup_reg <= 1'b1;
                        end
                        ACT_REMOVE:
                        begin
                            valid_reg[pipe_idx_reg] <= 1'b0;
                            count_reg <= count_reg + 7'd1;
                        end
                        default:
                        begin
                            hit_reg <= hit_reg;
                        end
                    endcase
                end
                if (pipe_vld_reg && !ent_valid && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                end
            end
            else if (state_reg == ST_FINISH)
            begin
                if (do_write)
                begin
                    valid_reg[free_idx_reg] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg      <= action_t'(action);
            addr_reg     <= address;
            pfx_reg      <= clamp_prefix(prefix_len);
            key_mask_reg <= mask_of(clamp_prefix(prefix_len));
        end
        if (state_reg == ST_SCAN)
        begin
            pipe_idx_reg <= idx_reg[IDX_W-1:0];
            if (pipe_vld_reg && !ent_valid && !free_found_reg)
            begin
                free_idx_reg <= pipe_idx_reg;
            end
        end
    end

    always_comb
    begin
        status = STS_ADDED;
        if (act_reg == ACT_INSERT)
        begin
            if (dup_reg)
            begin
                status = STS_DUP;
            end
            else if (!free_found_reg)
            begin
                status = STS_FULL;
            end
        end
    end

    assign hit           = hit_reg;
    assign removed_count = count_reg;

    a_count_only_remove: assert property (@(posedge clk) disable iff (!rst_n)
        done && (removed_count != 7'd0) |-> act_reg == ACT_REMOVE)
        else $error("removed_count set outside remove");

    a_hit_only_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        done && hit |-> act_reg == ACT_LOOKUP)
        else $error("hit set outside lookup");

    a_insert_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> valid_reg[$past(free_idx_reg)])
        else $error("inserted entry not marked valid");

    a_busy_ends_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(done))
        else $error("busy dropped without a result");

    a_done_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == ST_SCAN && $past(scan_end))
        else $error("result without a completed walk");

endmodule

>>> hw/rtl/cblm_ram.sv
module cblm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> test/cidr_ban_list_matcher_tb.sv
module cidr_ban_list_matcher_tb
    import cblm_pkg::*;
();

    localparam int CYCLE_LIMIT = 600000;
    localparam int ITEM_TARGET = 830;

    typedef struct packed {
        logic       hit;
        logic [1:0] status;
        logic [6:0] removed;
    } verdict_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        action;
    logic [ADDR_W-1:0] address;
    logic [PFX_W-1:0]  prefix_len;
    logic              done;
    logic              hit;
    logic [1:0]        status;
    logic [6:0]        removed_count;

    // shadow copy of the ban table
    bit                ban_valid [TABLE_ENTRIES];
    logic [ADDR_W-1:0] ban_addr [TABLE_ENTRIES];
    int unsigned       ban_pfx [TABLE_ENTRIES];

    verdict_t verdicts_pending [$];
    int       error_count;
    int       items_sent;
    int       cycle_count;
    int       burst_left;
    bit       steady;

    cidr_ban_list_matcher u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .address       (address),
        .prefix_len    (prefix_len),
        .done          (done),
        .hit           (hit),
        .status        (status),
        .removed_count (removed_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [ADDR_W-1:0] filter_mask(int unsigned plen);
        if (plen == 0)
        begin
            return '0;
        end
        return 32'hFFFF_FFFF << (32 - plen);
    endfunction

    function automatic bit filter_holds(int i, logic [ADDR_W-1:0] addr);
        return ((addr ^ ban_addr[i]) & filter_mask(ban_pfx[i])) == '0;
    endfunction

    function automatic int live_filters();
        int n;
        n = 0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            n += ban_valid[i];
        end
        return n;
    endfunction

    // applies one command to the shadow table, returns the expected result
    function automatic verdict_t ban_table_update(action_t act, logic [ADDR_W-1:0] addr,
                                                  logic [PFX_W-1:0] plen_in);
        verdict_t    v;
        int unsigned plen;
        logic [ADDR_W-1:0] key;
        bit          dup;
        int          free_slot;
        int          removed;
        v = '0;
        dup = 1'b0;
        free_slot = -1;
        removed = 0;
        case (act)
            ACT_LOOKUP:
            begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    if (ban_valid[i] && filter_holds(i, addr))
                    begin
                        v.hit = 1'b1;
                    end
                end
            end
            ACT_INSERT:
            begin
                plen = (plen_in > 32) ? 32 : plen_in;
                key = addr & filter_mask(plen);
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    if (ban_valid[i])
                    begin
                        if ((ban_addr[i] & filter_mask(ban_pfx[i])) == key)
                        begin
                            dup = 1'b1;
                        end
                    end
                    else if (free_slot < 0)
                    begin
                        free_slot = i;
                    end
                end
                if (dup)
                begin
                    v.status = STS_DUP;
                end
                else if (free_slot < 0)
                begin
                    v.status = STS_FULL;
                end
                else
                begin
                    v.status = STS_ADDED;
                    ban_valid[free_slot] = 1'b1;
                    ban_addr[free_slot] = addr;
                    ban_pfx[free_slot] = plen;
                end
            end
            ACT_REMOVE:
            begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    if (ban_valid[i] && filter_holds(i, addr))
                    begin
                        ban_valid[i] = 1'b0;
                        removed++;
                    end
                end
                v.removed = 7'(removed);
            end
            default:
            begin
            end
        endcase
        return v;
    endfunction

    // address inside some live filter, or random when the table is empty
    function automatic logic [ADDR_W-1:0] pick_banned_address();
        int idx [$];
        int i;
        logic [ADDR_W-1:0] m;
        for (int k = 0; k < TABLE_ENTRIES; k++)
        begin
            if (ban_valid[k])
            begin
                idx = {idx, k};
            end
        end
        if (idx.size() == 0)
        begin
            return $urandom;
        end
        i = idx[$urandom_range(0, idx.size() - 1)];
        m = filter_mask(ban_pfx[i]);
        if ($urandom_range(0, 1) == 0)
        begin
            return ban_addr[i];
        end
        return (ban_addr[i] & m) | (ADDR_W'($urandom) & ~m);
    endfunction

    function automatic logic [PFX_W-1:0] rand_prefix();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            return '0;
        end
        if (r < 14)
        begin
            return PFX_W'($urandom_range(1, 7));
        end
        if (r < 24)
        begin
            return PFX_W'($urandom_range(33, 63));
        end
        return PFX_W'($urandom_range(8, 32));
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] mismatch %s: got %0h expected %0h", $time, what, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && done === 1'b1)
        begin
            if (verdicts_pending.size() == 0)
            begin
                report_mismatch("result with nothing pending", {hit, status, removed_count}, 0);
            end
            else
            begin
                want = verdicts_pending.pop_front();
                if (hit !== want.hit)
                begin
                    report_mismatch("hit", hit, want.hit);
                end
                if (status !== want.status)
                begin
                    report_mismatch("status", status, want.status);
                end
                if (removed_count !== want.removed)
                begin
                    report_mismatch("removed_count", removed_count, want.removed);
                end
            end
        end
    end

    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
            if (gap > 0)
            begin
                @(negedge clk);
                start <= 1'b0;
                action <= 2'($urandom);
                address <= $urandom;
                prefix_len <= PFX_W'($urandom);
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic send_cmd(action_t act, logic [ADDR_W-1:0] addr, logic [PFX_W-1:0] plen);
        pace_sender();
        @(negedge clk);
        start <= 1'b1;
        action <= act;
        address <= addr;
        prefix_len <= plen;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        verdicts_pending = {verdicts_pending, ban_table_update(act, addr, plen)};
        items_sent++;
    endtask

    task automatic test_directed_cases();
        send_cmd(ACT_LOOKUP, 32'h0000_0000, 6'd0);
        send_cmd(ACT_REMOVE, 32'hFFFF_FFFF, 6'd63);
        send_cmd(ACT_INSERT, 32'hFFFF_FFFF, 6'd32);
        send_cmd(ACT_INSERT, 32'h0000_0000, 6'd32);
        send_cmd(ACT_LOOKUP, 32'hFFFF_FFFF, 6'd0);
        send_cmd(ACT_LOOKUP, 32'hFFFF_FFFE, 6'd0);
        send_cmd(ACT_INSERT, 32'hC0A8_0123, 6'd24);
        send_cmd(ACT_LOOKUP, 32'hC0A8_01FE, 6'd5);
        send_cmd(ACT_INSERT, 32'hC0A8_01AA, 6'd24);
        send_cmd(ACT_INSERT, 32'hC0A8_0100, 6'd16);
        // prefix above 32 saturates to a host filter
        send_cmd(ACT_INSERT, 32'h0A0B_0C0D, 6'd33);
        send_cmd(ACT_LOOKUP, 32'h0A0B_0C0D, 6'd0);
        send_cmd(ACT_LOOKUP, 32'h0A0B_0C0C, 6'd0);
        send_cmd(ACT_INSERT, 32'h1234_5678, 6'd63);
        send_cmd(ACT_NONE, 32'hFFFF_FFFF, 6'd63);
        // zero prefix collides with 0.0.0.0/32 on the masked key
        send_cmd(ACT_INSERT, 32'h8000_0000, 6'd0);
        send_cmd(ACT_REMOVE, 32'h0000_0000, 6'd0);
        send_cmd(ACT_INSERT, 32'h8000_0000, 6'd0);
        send_cmd(ACT_LOOKUP, 32'h5555_5555, 6'd0);
        send_cmd(ACT_REMOVE, 32'h5555_5555, 6'd0);
        send_cmd(ACT_REMOVE, 32'hC0A8_0177, 6'd0);
        send_cmd(ACT_INSERT, 32'h8000_0000, 6'd1);
        send_cmd(ACT_LOOKUP, 32'hFFFF_FFFF, 6'd0);
        send_cmd(ACT_NONE, 32'h0000_0000, 6'd0);
    endtask

    task automatic test_table_full();
        int tries;
        int i;
        tries = 0;
        while (live_filters() < TABLE_ENTRIES && tries < 300)
        begin
            send_cmd(ACT_INSERT, $urandom, PFX_W'($urandom_range(8, 32)));
            tries++;
        end
        send_cmd(ACT_INSERT, $urandom, 6'd32);
        send_cmd(ACT_INSERT, $urandom, 6'd40);
        // duplicate wins over full
        i = $urandom_range(0, TABLE_ENTRIES - 1);
        if (ban_valid[i])
        begin
            send_cmd(ACT_INSERT, ban_addr[i], PFX_W'(ban_pfx[i]));
        end
        repeat (4) send_cmd(ACT_LOOKUP, pick_banned_address(), rand_prefix());
        send_cmd(ACT_LOOKUP, $urandom, rand_prefix());
        while (live_filters() > 0)
        begin
            send_cmd(ACT_REMOVE, pick_banned_address(), rand_prefix());
        end
    endtask

    task automatic run_nested(logic [ADDR_W-1:0] base, int lo);
        for (int p = 32; p >= lo; p--)
        begin
            send_cmd(ACT_INSERT, base, PFX_W'(p));
        end
        send_cmd(ACT_LOOKUP, base, rand_prefix());
        send_cmd(ACT_REMOVE, base, rand_prefix());
    endtask

    task automatic test_nested_prefixes();
        run_nested(32'hFFFF_FFFF, 0);
    endtask

    task automatic test_random_traffic();
        int kind;
        int n;
        int r;
        action_t act;
        logic [ADDR_W-1:0] addr;
        while (items_sent < ITEM_TARGET)
        begin
            steady = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 9);
            if (kind <= 5)
            begin
                n = $urandom_range(5, 30);
                repeat (n)
                begin
                    r = $urandom_range(0, 99);
                    act = (r < 35) ? ACT_LOOKUP : (r < 72) ? ACT_INSERT :
                          (r < 95) ? ACT_REMOVE : ACT_NONE;
                    addr = ($urandom_range(0, 9) < 6) ? pick_banned_address() : $urandom;
                    send_cmd(act, addr, rand_prefix());
                end
            end
            else if (kind <= 7)
            begin
                run_nested($urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : $urandom,
                           $urandom_range(8, 32));
            end
            else if (kind == 8)
            begin
                test_table_full();
            end
            else
            begin
                n = $urandom_range(1, 8);
                repeat (n) send_cmd(ACT_REMOVE, pick_banned_address(), rand_prefix());
            end
        end
    endtask

    task automatic finish_run();
        @(negedge clk);
        start <= 1'b0;
        while (verdicts_pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TABLE_ENTRIES + 8) @(posedge clk);
        if (error_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        action = ACT_LOOKUP;
        address = '0;
        prefix_len = '0;
        error_count = 0;
        items_sent = 0;
        cycle_count = 0;
        burst_left = 0;
        steady = 1'b0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            ban_valid[i] = 1'b0;
            ban_addr[i] = '0;
            ban_pfx[i] = 0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed_cases();
        test_table_full();
        test_nested_prefixes();
        test_random_traffic();
        finish_run();
    end

endmodule
